// ----- design/mbet_pkg.sv -----
// ----------------------------------------------------------------------------
// mbet_pkg
// Shared types and fixed widths of the escape-time pixel unit.
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int IDX_W   = 24;
    localparam int SIZE_W  = 13;
    localparam int LIMIT_W = 16;
    localparam int PAN_W   = 21;
    localparam int ZOOM_W  = 32;
    localparam int SHADE_W = 8;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;

    typedef enum logic [ADDR_W-1:0] {
        ADDR_WIDTH  = 3'd0,
        ADDR_HEIGHT = 3'd1,
        ADDR_LIMIT  = 3'd2,
        ADDR_PAN_X  = 3'd3,
        ADDR_PAN_Y  = 3'd4,
        ADDR_ZOOM   = 3'd5
    } cfg_addr_t;

    typedef enum logic [1:0] {
        DSEL_SPLIT = 2'd0,
        DSEL_ZOOM  = 2'd1,
        DSEL_SCALE = 2'd2,
        DSEL_SHADE = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
        logic [LIMIT_W-1:0]        limit;
        logic signed [PAN_W-1:0]   pan_x;
        logic signed [PAN_W-1:0]   pan_y;
        logic [ZOOM_W-1:0]         zoom;
    } cfg_t;

    typedef struct packed {
        logic     in_load;
        logic     div_load;
        logic     div_step;
        div_sel_t div_sel;
        logic     axis;
        logic     cap_split;
        logic     mul_load;
        logic     mul_step;
        logic     cap_coord;
        logic     iter_clear;
        logic     iter_sq;
        logic     iter_upd;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic cont;
    } status_t;

endpackage

// ----- design/mbet_div.sv -----
// ----------------------------------------------------------------------------
// mbet_div
// Restoring divider, one quotient bit per step, dividend left aligned.
// ----------------------------------------------------------------------------
module mbet_div #(
    parameter int Q_W = 84,
    parameter int D_W = 32
) (
    input  logic           clk,
    input  logic           load,
    input  logic           step,
    input  logic [Q_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [Q_W-1:0] quot,
    output logic [D_W-1:0] rem
);

    logic [Q_W-1:0] q_reg;
    logic [D_W-1:0] r_reg;
    logic [D_W-1:0] d_reg;
    logic [D_W:0]   r_sh;
    logic [D_W:0]   r_diff;

    assign r_sh   = {r_reg, q_reg[Q_W-1]};
    assign r_diff = r_sh - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (step)
        begin
            if (!r_diff[D_W])
            begin
                r_reg <= r_diff[D_W-1:0];
                q_reg <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh[D_W-1:0];
                q_reg <= {q_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- design/mbet_datapath.sv -----
// ----------------------------------------------------------------------------
// mbet_datapath
// Index split, coordinate mapping, orbit iteration and result registers.
// ----------------------------------------------------------------------------
module mbet_datapath #(
    parameter int FRAC_BITS = 25
) (
    input  logic                          clk,
    input  mbet_pkg::cfg_t                cfg,
    input  mbet_pkg::cmd_t                cmd,
    input  logic [mbet_pkg::IDX_W-1:0]    in_index,
    output mbet_pkg::status_t             status,
    output logic [mbet_pkg::IDX_W-1:0]    out_index,
    output logic [mbet_pkg::LIMIT_W-1:0]  out_count,
    output logic [mbet_pkg::SHADE_W-1:0]  out_shade
);

    localparam int IDX_W  = mbet_pkg::IDX_W;
    localparam int WORD_W = FRAC_BITS + 7;
    localparam int SPAN_W = FRAC_BITS + 2;
    localparam int P_W    = IDX_W + 32;
    localparam int S_W    = P_W + 2;
    localparam int MAG_W  = S_W - 1;
    localparam int PROD_W = MAG_W + SPAN_W;
    localparam int DIV_W  = PROD_W;
    localparam int DVS_W  = mbet_pkg::ZOOM_W;
    localparam int SAT_W  = 2 * WORD_W - FRAC_BITS;
    localparam int V_W    = WORD_W + 4;

    localparam logic [SPAN_W-1:0] X_SPAN = SPAN_W'((64'd247 << (FRAC_BITS - 2)) / 64'd25);
    localparam logic [SPAN_W-1:0] Y_SPAN = SPAN_W'((64'd56 << FRAC_BITS) / 64'd25);
    localparam logic [WORD_W-1:0] X_OFF  = WORD_W'(64'd2 << FRAC_BITS);
    localparam logic [WORD_W-1:0] Y_OFF  = WORD_W'((64'd28 << FRAC_BITS) / 64'd25);
    localparam logic [WORD_W-1:0] ESCAPE = WORD_W'(64'd4 << FRAC_BITS);

    localparam logic signed [SAT_W-1:0] SMAX =
        {{(SAT_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SMIN = ~SMAX;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SMAX)
            r = SMAX[WORD_W-1:0];
        else if (v < SMIN)
            r = SMIN[WORD_W-1:0];
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [SAT_W-1:0] ext(input logic signed [WORD_W-1:0] a);
        return {{(SAT_W-WORD_W){a[WORD_W-1]}}, a};
    endfunction

    logic [IDX_W-1:0]                  idx_reg;
    logic [IDX_W-1:0]                  col_reg;
    logic [IDX_W-1:0]                  row_reg;
    logic [PROD_W-1:0]                 acc_reg;
    logic [MAG_W-1:0]                  mcand_reg;
    logic [SPAN_W-1:0]                 span_reg;
    logic                              neg_reg;
    logic signed [WORD_W-1:0]          cx_reg;
    logic signed [WORD_W-1:0]          cy_reg;
    logic signed [WORD_W-1:0]          x_reg;
    logic signed [WORD_W-1:0]          y_reg;
    logic signed [WORD_W-1:0]          x2_reg;
    logic signed [WORD_W-1:0]          y2_reg;
    logic signed [WORD_W-1:0]          xy_reg;
    logic [mbet_pkg::LIMIT_W-1:0]      count_reg;
    logic [IDX_W-1:0]                  out_index_reg;
    logic [mbet_pkg::LIMIT_W-1:0]      out_count_reg;
    logic [mbet_pkg::SHADE_W-1:0]      out_shade_reg;

    logic [DIV_W-1:0]                  div_dividend;
    logic [DVS_W-1:0]                  div_divisor;
    logic [DIV_W-1:0]                  div_quot;
    logic [DVS_W-1:0]                  div_rem;
    logic [IDX_W-1:0]                  pos;
    logic [mbet_pkg::SIZE_W-1:0]       size;
    logic signed [mbet_pkg::PAN_W-1:0] pan;
    logic signed [S_W-1:0]             pan_ext;
    logic signed [S_W-1:0]             s_val;
    logic signed [S_W-1:0]             s_abs;
    logic                              s_neg;
    logic                              q_big;
    logic [WORD_W+1:0]                 qc;
    logic                              round_up;
    logic signed [V_W-1:0]             qv;
    logic signed [V_W-1:0]             tv;
    logic signed [V_W-1:0]             cv;
    logic [WORD_W-1:0]                 off;
    logic signed [WORD_W-1:0]          coord;
    logic signed [2*WORD_W-1:0]        p_xx;
    logic signed [2*WORD_W-1:0]        p_yy;
    logic signed [2*WORD_W-1:0]        p_xy;
    logic signed [SAT_W-1:0]           y_sum;
    logic signed [SAT_W-1:0]           x_sum;
    logic signed [SAT_W-1:0]           mag_sum;

    mbet_div #(
        .Q_W (DIV_W),
        .D_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign pos  = cmd.axis ? row_reg : col_reg;
    assign size = cmd.axis ? cfg.height : cfg.width;
    assign pan  = cmd.axis ? cfg.pan_y : cfg.pan_x;
    assign off  = cmd.axis ? Y_OFF : X_OFF;

    always_comb
    begin
        div_dividend = {idx_reg, {(DIV_W-IDX_W){1'b0}}};
        div_divisor  = DVS_W'(cfg.width);
        case (cmd.div_sel)
            mbet_pkg::DSEL_SPLIT:
            begin
                div_dividend = {idx_reg, {(DIV_W-IDX_W){1'b0}}};
                div_divisor  = DVS_W'(cfg.width);
            end
            mbet_pkg::DSEL_ZOOM:
            begin
                div_dividend = {pos, 32'd0, {(DIV_W-P_W){1'b0}}};
                div_divisor  = cfg.zoom;
            end
            mbet_pkg::DSEL_SCALE:
            begin
                div_dividend = acc_reg;
                div_divisor  = DVS_W'({size, 16'd0});
            end
            mbet_pkg::DSEL_SHADE:
            begin
                div_dividend = {count_reg, 8'd0, {(DIV_W-IDX_W){1'b0}}};
                div_divisor  = DVS_W'(cfg.limit);
            end
            default:
            begin
                div_dividend = {idx_reg, {(DIV_W-IDX_W){1'b0}}};
                div_divisor  = DVS_W'(cfg.width);
            end
        endcase
    end

    // offset point before scaling: col or row over zoom in Q.16 plus pan
    assign pan_ext = {{(S_W-mbet_pkg::PAN_W-16){pan[mbet_pkg::PAN_W-1]}}, pan, 16'd0};
    assign s_val   = $signed({2'b00, div_quot[P_W-1:0]}) + pan_ext;
    assign s_neg   = s_val[S_W-1];
    assign s_abs   = s_neg ? -s_val : s_val;

    // floor of signed quotient, clamped, offset and saturated
    assign q_big    = |div_quot[DIV_W-1:WORD_W+1];
    assign qc       = q_big ? {1'b1, {(WORD_W+1){1'b0}}} : {1'b0, div_quot[WORD_W:0]};
    assign round_up = neg_reg && (div_rem != '0);
    assign qv       = $signed({2'b00, qc}) + $signed({{(V_W-1){1'b0}}, round_up});
    assign tv       = neg_reg ? -qv : qv;
    assign cv       = tv - $signed({4'b0000, off});
    assign coord    = sat_word({{(SAT_W-V_W){cv[V_W-1]}}, cv});

    assign p_xx    = x_reg * x_reg;
    assign p_yy    = y_reg * y_reg;
    assign p_xy    = x_reg * y_reg;
    assign y_sum   = (ext(xy_reg) <<< 1) + ext(cy_reg);
    assign x_sum   = ext(x2_reg) - ext(y2_reg) + ext(cx_reg);
    assign mag_sum = ext(x2_reg) + ext(y2_reg);

    assign status.cont = (mag_sum <= $signed({{(SAT_W-WORD_W){1'b0}}, ESCAPE}))
                         && (count_reg < cfg.limit);

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
            idx_reg <= in_index;
        if (cmd.cap_split)
        begin
            col_reg <= div_rem[IDX_W-1:0];
            row_reg <= div_quot[IDX_W-1:0];
        end
        if (cmd.mul_load)
        begin
            acc_reg   <= '0;
            mcand_reg <= s_abs[MAG_W-1:0];
            neg_reg   <= s_neg;
            span_reg  <= cmd.axis ? Y_SPAN : X_SPAN;
        end
        else if (cmd.mul_step)
        begin
            if (span_reg[SPAN_W-1])
                acc_reg <= {acc_reg[PROD_W-2:0], 1'b0} + PROD_W'(mcand_reg);
            else
                acc_reg <= {acc_reg[PROD_W-2:0], 1'b0};
            span_reg <= {span_reg[SPAN_W-2:0], 1'b0};
        end
        if (cmd.cap_coord)
        begin
            if (cmd.axis)
                cy_reg <= coord;
            else
                cx_reg <= coord;
        end
        if (cmd.iter_clear)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            x2_reg    <= '0;
            y2_reg    <= '0;
            xy_reg    <= '0;
            count_reg <= '0;
        end
        else if (cmd.iter_sq)
        begin
            x2_reg <= sat_word($signed(p_xx[2*WORD_W-1:FRAC_BITS]));
            y2_reg <= sat_word($signed(p_yy[2*WORD_W-1:FRAC_BITS]));
            xy_reg <= sat_word($signed(p_xy[2*WORD_W-1:FRAC_BITS]));
        end
        else if (cmd.iter_upd)
        begin
            y_reg     <= sat_word(y_sum);
            x_reg     <= sat_word(x_sum);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_index_reg <= idx_reg;
            out_count_reg <= count_reg;
            out_shade_reg <= (cfg.limit == '0) ? '0 : div_quot[mbet_pkg::SHADE_W-1:0];
        end
    end

    assign out_index = out_index_reg;
    assign out_count = out_count_reg;
    assign out_shade = out_shade_reg;

endmodule

// ----- design/mbet_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbet_ctrl
// Sequencer: steps the divider, scaler and orbit loop for one pixel.
// ----------------------------------------------------------------------------
module mbet_ctrl #(
    parameter int FRAC_BITS = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mbet_pkg::status_t status,
    output mbet_pkg::cmd_t    cmd
);

    localparam int SPLIT_LEN = mbet_pkg::IDX_W;
    localparam int ZOOM_LEN  = mbet_pkg::IDX_W + 32;
    localparam int SPAN_LEN  = FRAC_BITS + 2;
    localparam int SCALE_LEN = mbet_pkg::IDX_W + 33 + SPAN_LEN;
    localparam int CNT_W     = $clog2(SCALE_LEN + 1);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SPLIT  = 11'b00000000010,
        ST_CAPT   = 11'b00000000100,
        ST_ZOOM   = 11'b00000001000,
        ST_MUL    = 11'b00000010000,
        ST_SCALE  = 11'b00000100000,
        ST_COORD  = 11'b00001000000,
        ST_CHECK  = 11'b00010000000,
        ST_SQUARE = 11'b00100000000,
        ST_SHADE  = 11'b01000000000,
        ST_FINISH = 11'b10000000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             axis_reg;
    logic             axis_next;
    logic             valid_reg;
    logic             valid_next;
    logic [CNT_W-1:0] len;
    logic             last;

    always_comb
    begin
        case (state_reg)
            ST_ZOOM:  len = CNT_W'(ZOOM_LEN);
            ST_MUL:   len = CNT_W'(SPAN_LEN);
            ST_SCALE: len = CNT_W'(SCALE_LEN);
            default:  len = CNT_W'(SPLIT_LEN);
        endcase
    end

    assign last = (cnt_reg == len);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                cmd.div_sel  = mbet_pkg::DSEL_SPLIT;
                cmd.div_load = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
                if (last)
                    state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                cmd.cap_split = 1'b1;
                axis_next     = 1'b0;
                state_next    = ST_ZOOM;
            end
            ST_ZOOM:
            begin
                cmd.div_sel  = mbet_pkg::DSEL_ZOOM;
                cmd.div_load = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
                if (last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_load = (cnt_reg == '0);
                cmd.mul_step = (cnt_reg != '0);
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
                if (last)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.div_sel  = mbet_pkg::DSEL_SCALE;
                cmd.div_load = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
                if (last)
                    state_next = ST_COORD;
            end
            ST_COORD:
            begin
                cmd.cap_coord = 1'b1;
                if (!axis_reg)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_ZOOM;
                end
                else
                begin
                    cmd.iter_clear = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.cont)
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = ST_SQUARE;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SHADE;
                end
            end
            ST_SQUARE:
            begin
                cmd.iter_sq = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_SHADE:
            begin
                cmd.div_sel  = mbet_pkg::DSEL_SHADE;
                cmd.div_load = (cnt_reg == '0);
                cmd.div_step = (cnt_reg != '0);
                cnt_next     = last ? '0 : cnt_reg + 1'b1;
                if (last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

endmodule

// ----- design/mandelbrot_escape_time_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// Escape-time pixel engine: maps a pixel index to c and counts orbit steps.
//
//   channel  dir  beat fields (lsb up)
//   s_*      in   pixel_index[23:0]
//   m_*      out  pixel_index_out[23:0], iteration_count[39:24], shade[47:40]
//   cfg_*    in   write enable, register index, 32-bit data
//
// A shared bit-serial divider splits the index, maps both axes (zoom
// and scale divisions) and forms the shade; the orbit loop runs a check
// and update state, then a squaring state, per iteration. One pixel is in
// work at a time.
// A finished beat waits in the output register while the next pixel starts.
// Reset restores the register defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int FRAC_BITS  = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // pixel_index
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // pixel_index_out, iteration_count, shade
    input  logic                          cfg_wr_en,
    input  logic [mbet_pkg::ADDR_W-1:0]   cfg_index,
    input  logic [mbet_pkg::CFG_W-1:0]    cfg_data
);

    logic [mbet_pkg::SIZE_W-1:0]       width_reg;
    logic [mbet_pkg::SIZE_W-1:0]       height_reg;
    logic [mbet_pkg::LIMIT_W-1:0]      limit_reg;
    logic signed [mbet_pkg::PAN_W-1:0] pan_x_reg;
    logic signed [mbet_pkg::PAN_W-1:0] pan_y_reg;
    logic [mbet_pkg::ZOOM_W-1:0]       zoom_reg;

    mbet_pkg::cfg_t                    cfg;
    mbet_pkg::cmd_t                    cmd;
    mbet_pkg::status_t                 status;
    logic [mbet_pkg::IDX_W-1:0]        out_index;
    logic [mbet_pkg::LIMIT_W-1:0]      out_count;
    logic [mbet_pkg::SHADE_W-1:0]      out_shade;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            limit_reg  <= 16'd256;
            pan_x_reg  <= '0;
            pan_y_reg  <= '0;
            zoom_reg   <= 32'd65536;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mbet_pkg::ADDR_WIDTH:  width_reg  <= cfg_data[mbet_pkg::SIZE_W-1:0];
                mbet_pkg::ADDR_HEIGHT: height_reg <= cfg_data[mbet_pkg::SIZE_W-1:0];
                mbet_pkg::ADDR_LIMIT:  limit_reg  <= cfg_data[mbet_pkg::LIMIT_W-1:0];
                mbet_pkg::ADDR_PAN_X:  pan_x_reg  <= $signed(cfg_data[mbet_pkg::PAN_W-1:0]);
                mbet_pkg::ADDR_PAN_Y:  pan_y_reg  <= $signed(cfg_data[mbet_pkg::PAN_W-1:0]);
                mbet_pkg::ADDR_ZOOM:   zoom_reg   <= cfg_data[mbet_pkg::ZOOM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp sizes to one and the maximum, zero zoom to one lsb
    always_comb
    begin
        if (width_reg == '0)
            cfg.width = mbet_pkg::SIZE_W'(1);
        else if (width_reg > MAX_WIDTH)
            cfg.width = mbet_pkg::SIZE_W'(MAX_WIDTH);
        else
            cfg.width = width_reg;
        if (height_reg == '0)
            cfg.height = mbet_pkg::SIZE_W'(1);
        else if (height_reg > MAX_HEIGHT)
            cfg.height = mbet_pkg::SIZE_W'(MAX_HEIGHT);
        else
            cfg.height = height_reg;
        cfg.limit = limit_reg;
        cfg.pan_x = pan_x_reg;
        cfg.pan_y = pan_y_reg;
        cfg.zoom  = (zoom_reg == '0) ? mbet_pkg::ZOOM_W'(1) : zoom_reg;
    end

    mbet_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mbet_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .cfg       (cfg),
        .cmd       (cmd),
        .in_index  (s_tdata),
        .status    (status),
        .out_index (out_index),
        .out_count (out_count),
        .out_shade (out_shade)
    );

    assign m_tdata = {out_shade, out_count, out_index};

endmodule
